/* src/pfba_pkg.sv */
package pfba_pkg;

  // default sizing
  localparam int unsigned NUM_PAGES_DEF  = 65536;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // fixed field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned MAP_BITS = 32;
  localparam int unsigned BIT_W    = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_ADD     = 2'd2,
    MODE_RESERVE = 2'd3
  } mode_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_t;

  // position of the lowest clear bit in a map word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } zero_pos_t;

  // controls from the sequencer to the free-word index
  typedef struct packed {
    logic clear;
    logic find;
    logic read;
    logic update;
    logic upd_full;
  } fidx_ctl_t;

  function automatic zero_pos_t lowest_zero(input logic [MAP_BITS-1:0] w);
    zero_pos_t r;
    r = '0;
    for (int i = MAP_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

  // saturating counter steps
  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

endpackage

/* src/pfba_free_index.sv */
module pfba_free_index #(
  parameter int unsigned SUM_WORDS = 64,
  parameter int unsigned SUM_AW    = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pfba_pkg::fidx_ctl_t              ctl,
  input  logic [SUM_AW-1:0]                clear_addr,
  input  logic [SUM_AW-1:0]                rd_group,
  input  logic [pfba_pkg::BIT_W-1:0]       upd_bit,
  output logic                             any_free,
  output logic [SUM_AW+pfba_pkg::BIT_W-1:0] found_word
);

  // one bit per map word: set when the word has no clear page
  logic [pfba_pkg::MAP_BITS-1:0] sum_mem [SUM_WORDS];
  logic [pfba_pkg::MAP_BITS-1:0] sum_rd_r;
  logic [SUM_AW-1:0]             group_r;
  // one bit per summary word: set when every map word of the group is full
  logic [SUM_WORDS-1:0]          grp_full_r;

  logic [SUM_AW-1:0]             first_group;
  logic [pfba_pkg::MAP_BITS-1:0] upd_mask;
  logic [pfba_pkg::MAP_BITS-1:0] sum_nxt;
  logic                          wr_en;
  logic [SUM_AW-1:0]             wr_addr;
  logic [pfba_pkg::MAP_BITS-1:0] wr_data;
  pfba_pkg::zero_pos_t           sum_zero;

  // lowest group that still holds a free page
  always_comb begin
    first_group = '0;
    for (int i = SUM_WORDS - 1; i >= 0; i--) begin
      if (!grp_full_r[i]) begin
        first_group = SUM_AW'(i);
      end
    end
  end

  assign any_free   = ~&grp_full_r;
  assign sum_zero   = pfba_pkg::lowest_zero(sum_rd_r);
  assign found_word = {group_r, sum_zero.idx};

  // summary word after the map word changed its full flag
  assign upd_mask = pfba_pkg::MAP_BITS'(1) << upd_bit;
  assign sum_nxt  = ctl.upd_full ? (sum_rd_r | upd_mask) : (sum_rd_r & ~upd_mask);

  always_comb begin
    wr_en   = ctl.clear | ctl.update;
    wr_addr = ctl.clear ? clear_addr : group_r;
    wr_data = ctl.clear ? '1 : sum_nxt;
  end

  // summary memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[wr_addr] <= wr_data;
    end
  end

  // summary memory read port, data held until the next read
  always_ff @(posedge clk) begin
    if (ctl.find) begin
      sum_rd_r <= sum_mem[first_group];
      group_r  <= first_group;
    end else if (ctl.read) begin
      sum_rd_r <= sum_mem[rd_group];
      group_r  <= rd_group;
    end
  end

  // group full flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_full_r <= '1;
    end else if (ctl.update) begin
      grp_full_r[group_r] <= &sum_nxt;
    end
  end

endmodule

/* src/page_frame_bitmap_allocator_top.sv */
// chan | handshake           | fields
// in_  | in_valid/in_stall   | in_mode, in_address
// out_ | out_valid/out_stall | out_page_address, out_status, out_free_count, out_total_count
// cfg_ | cfg_valid/cfg_ready | cfg_kernel_end_address
//
// free, add and reserve do a bitmap memory read, then a read-modify-write step that
// loads the result; alloc, when a page is free, does a summary read before the bitmap memory read
// after reset the bitmap memory is swept one word per cycle, all MAP_WORDS words
// (2048 by default), with in_stall high
// out_stall holds only the write-back cycle; the next beat is taken while a result
// waits. cfg_ready is always high
module page_frame_bitmap_allocator_top #(
  parameter int unsigned NUM_PAGES  = pfba_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = pfba_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfba_pkg::MODE_W-1:0]   in_mode,
  input  logic [pfba_pkg::ADDR_W-1:0]   in_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfba_pkg::ADDR_W-1:0]   out_page_address,
  output logic [pfba_pkg::STATUS_W-1:0] out_status,
  output logic [pfba_pkg::COUNT_W-1:0]  out_free_count,
  output logic [pfba_pkg::COUNT_W-1:0]  out_total_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfba_pkg::ADDR_W-1:0]   cfg_kernel_end_address
);

  // sizing; page size must be a power of two, the block itself does not enforce it
  localparam int unsigned MAP_BITS   = pfba_pkg::MAP_BITS;
  localparam int unsigned BIT_W      = pfba_pkg::BIT_W;
  localparam int unsigned ADDR_W     = pfba_pkg::ADDR_W;
  localparam int unsigned MAP_WORDS  = (NUM_PAGES + MAP_BITS - 1) / MAP_BITS;
  localparam int unsigned SUM_WORDS  = (MAP_WORDS + MAP_BITS - 1) / MAP_BITS;
  localparam int unsigned MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SUM_AW     = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int unsigned WORD_W     = SUM_AW + BIT_W;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
  localparam int unsigned IDX_W      =
    ((PAGE_NUM_W > WORD_W + BIT_W) ? PAGE_NUM_W : WORD_W + BIT_W) + 1;
  localparam int unsigned PA_W       = IDX_W + PAGE_SHIFT;
  localparam int unsigned COUNT_W    = pfba_pkg::COUNT_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_FIND  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [MAP_AW-1:0]            clr_cnt_r;
  logic [ADDR_W-1:0]            kernel_end_r;
  logic [COUNT_W-1:0]           free_cnt_r, free_cnt_nxt;
  logic [COUNT_W-1:0]           total_cnt_r, total_cnt_nxt;
  pfba_pkg::mode_t              op_mode_r;
  logic [ADDR_W-1:0]            op_addr_r;
  logic                         op_fail_r;
  logic [WORD_W-1:0]            word_r;

  // bitmap memory: owned bits in the upper half, used bits in the lower half
  logic [2*MAP_BITS-1:0]        map_mem [MAP_WORDS];
  logic [2*MAP_BITS-1:0]        map_rd_r;
  logic                         map_rd_en;
  logic [MAP_AW-1:0]            map_rd_addr;
  logic                         map_wr_en;
  logic [MAP_AW-1:0]            map_wr_addr;
  logic [2*MAP_BITS-1:0]        map_wr_data;

  logic                         out_valid_r;
  logic [ADDR_W-1:0]            out_page_address_r;
  pfba_pkg::status_t            out_status_r;
  logic [COUNT_W-1:0]           out_free_count_r;
  logic [COUNT_W-1:0]           out_total_count_r;

  pfba_pkg::mode_t              in_op;
  logic                         in_acc;
  logic [IDX_W-1:0]             in_page;
  logic                         in_range;
  logic [WORD_W-1:0]            in_word;

  pfba_pkg::fidx_ctl_t          fctl;
  logic                         any_free;
  logic [WORD_W-1:0]            found_word;
  logic                         clr_sum;
  logic                         clr_last;

  logic [IDX_W-1:0]             ex_page;
  logic                         ex_range;
  logic                         ex_aligned;
  logic                         ex_above;
  logic                         ex_done;
  logic [MAP_BITS-1:0]          used_w, owned_w;
  pfba_pkg::zero_pos_t          used_zero;
  logic [BIT_W-1:0]             ex_bit;
  logic [MAP_BITS-1:0]          ex_mask;
  logic                         used_bit, owned_bit;
  logic [IDX_W-1:0]             alloc_page;
  logic [PA_W-1:0]              alloc_pa_full;
  logic [MAP_BITS-1:0]          new_used, new_owned;
  logic                         ex_wr;
  logic                         f_inc, f_dec, t_inc;
  pfba_pkg::status_t            ex_status;
  logic [ADDR_W-1:0]            ex_pa;

  // input side decode
  assign in_op    = pfba_pkg::mode_t'(in_mode);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_page  = IDX_W'(in_address[ADDR_W-1:PAGE_SHIFT]);
  assign in_range = in_page < IDX_W'(NUM_PAGES);
  assign in_word  = in_page[WORD_W+BIT_W-1:BIT_W];

  assign cfg_ready = 1'b1;

  // clear sweep
  assign clr_last = (clr_cnt_r == MAP_AW'(MAP_WORDS - 1));
  assign clr_sum  = ({1'b0, clr_cnt_r} < (MAP_AW + 1)'(SUM_WORDS));

  // free-word index controls
  always_comb begin
    fctl.clear    = (state_r == ST_CLEAR) && clr_sum;
    fctl.find     = in_acc && (in_op == pfba_pkg::MODE_ALLOC) && any_free;
    fctl.read     = in_acc && (in_op != pfba_pkg::MODE_ALLOC) && in_range;
    fctl.update   = ex_done && ex_wr;
    fctl.upd_full = &new_used;
  end

  pfba_free_index #(
    .SUM_WORDS (SUM_WORDS),
    .SUM_AW    (SUM_AW)
  ) u_free_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (fctl),
    .clear_addr (clr_cnt_r[SUM_AW-1:0]),
    .rd_group   (in_word[WORD_W-1:BIT_W]),
    .upd_bit    (word_r[BIT_W-1:0]),
    .any_free   (any_free),
    .found_word (found_word)
  );

  // execute-cycle decode
  assign ex_page    = IDX_W'(op_addr_r[ADDR_W-1:PAGE_SHIFT]);
  assign ex_range   = ex_page < IDX_W'(NUM_PAGES);
  assign ex_aligned = (op_addr_r[PAGE_SHIFT-1:0] == '0);
  assign ex_above   = (op_addr_r >= kernel_end_r);
  assign ex_done    = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  assign used_w        = map_rd_r[MAP_BITS-1:0];
  assign owned_w       = map_rd_r[2*MAP_BITS-1:MAP_BITS];
  assign used_zero     = pfba_pkg::lowest_zero(used_w);
  assign ex_bit        = (op_mode_r == pfba_pkg::MODE_ALLOC) ? used_zero.idx
                                                            : ex_page[BIT_W-1:0];
  assign ex_mask       = MAP_BITS'(1) << ex_bit;
  assign used_bit      = used_w[ex_bit];
  assign owned_bit     = owned_w[ex_bit];
  assign alloc_page    = IDX_W'({word_r, used_zero.idx});
  assign alloc_pa_full = {alloc_page, {PAGE_SHIFT{1'b0}}};

  // per-operation bitmap and counter update
  always_comb begin
    new_used  = used_w;
    new_owned = owned_w;
    ex_wr     = 1'b0;
    f_inc     = 1'b0;
    f_dec     = 1'b0;
    t_inc     = 1'b0;
    ex_status = pfba_pkg::STATUS_IGNORED;
    ex_pa     = '0;
    unique case (op_mode_r)
      pfba_pkg::MODE_ALLOC: begin
        if (op_fail_r) begin
          ex_status = pfba_pkg::STATUS_NO_FREE;
        end else begin
          new_used  = used_w | ex_mask;
          new_owned = owned_w | ex_mask;
          ex_wr     = 1'b1;
          f_dec     = 1'b1;
          ex_status = pfba_pkg::STATUS_DONE;
          ex_pa     = alloc_pa_full[ADDR_W-1:0];
        end
      end
      pfba_pkg::MODE_FREE: begin
        if (ex_aligned && ex_above && ex_range && owned_bit) begin
          new_owned = owned_w & ~ex_mask;
          ex_wr     = 1'b1;
          ex_status = pfba_pkg::STATUS_DONE;
          if (used_bit) begin
            new_used = used_w & ~ex_mask;
            f_inc    = 1'b1;
          end
        end
      end
      pfba_pkg::MODE_ADD: begin
        if (ex_range && used_bit) begin
          new_used  = used_w & ~ex_mask;
          ex_wr     = 1'b1;
          f_inc     = 1'b1;
          t_inc     = 1'b1;
          ex_status = pfba_pkg::STATUS_DONE;
        end
      end
      pfba_pkg::MODE_RESERVE: begin
        if (ex_range && !used_bit) begin
          new_used  = used_w | ex_mask;
          ex_wr     = 1'b1;
          f_dec     = 1'b1;
          ex_status = pfba_pkg::STATUS_DONE;
        end
      end
      default: begin
        ex_status = pfba_pkg::STATUS_IGNORED;
      end
    endcase
  end

  always_comb begin
    priority if (f_inc) begin
      free_cnt_nxt = pfba_pkg::count_up(free_cnt_r);
    end else if (f_dec) begin
      free_cnt_nxt = pfba_pkg::count_down(free_cnt_r);
    end else begin
      free_cnt_nxt = free_cnt_r;
    end
    total_cnt_nxt = t_inc ? pfba_pkg::count_up(total_cnt_r) : total_cnt_r;
  end

  // bitmap memory port selection
  always_comb begin
    map_rd_en   = 1'b0;
    map_rd_addr = in_word[MAP_AW-1:0];
    if (state_r == ST_FIND) begin
      map_rd_en   = 1'b1;
      map_rd_addr = found_word[MAP_AW-1:0];
    end else if (fctl.read) begin
      map_rd_en   = 1'b1;
    end
    map_wr_en   = (state_r == ST_CLEAR) || (ex_done && ex_wr);
    map_wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : word_r[MAP_AW-1:0];
    map_wr_data = (state_r == ST_CLEAR) ? {{MAP_BITS{1'b0}}, {MAP_BITS{1'b1}}}
                                         : {new_owned, new_used};
  end

  always_ff @(posedge clk) begin
    if (map_wr_en) begin
      map_mem[map_wr_addr] <= map_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (map_rd_en) begin
      map_rd_r <= map_mem[map_rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = fctl.find ? ST_FIND : ST_EXEC;
        end
      end
      ST_FIND:  state_nxt = ST_EXEC;
      ST_EXEC:  if (ex_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      free_cnt_r  <= '0;
      total_cnt_r <= '0;
      kernel_end_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        kernel_end_r <= cfg_kernel_end_address;
      end
      if (ex_done) begin
        free_cnt_r  <= free_cnt_nxt;
        total_cnt_r <= total_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_mode_r <= in_op;
      op_addr_r <= in_address;
      op_fail_r <= (in_op == pfba_pkg::MODE_ALLOC) && !any_free;
      word_r    <= in_word;
    end else if (state_r == ST_FIND) begin
      word_r    <= found_word;
    end
    if (ex_done) begin
      out_page_address_r <= ex_pa;
      out_status_r       <= ex_status;
      out_free_count_r   <= free_cnt_nxt;
      out_total_count_r  <= total_cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_page_address = out_page_address_r;
  assign out_status       = out_status_r;
  assign out_free_count   = out_free_count_r;
  assign out_total_count  = out_total_count_r;

endmodule

/* src/pfba_checker.sv */
module pfba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pfba_pkg::ADDR_W-1:0]   out_page_address,
  input logic [pfba_pkg::STATUS_W-1:0] out_status,
  input logic [pfba_pkg::COUNT_W-1:0]  out_free_count,
  input logic [pfba_pkg::COUNT_W-1:0]  out_total_count
);

  // reset starts the clearing sweep, so no beat is taken right after it
  a_reset_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // only a successful alloc carries a page address
  a_addr_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pfba_pkg::STATUS_DONE) |-> out_page_address == '0)
    else $error("page address on a failed or ignored beat");

  // no page can be free that was never made available
  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_count <= out_total_count)
    else $error("free count above total count");

  // a stalled result beat holds its status, free count and page address
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_free_count) && $stable(out_page_address))
    else $error("stalled result beat changed");

endmodule

bind page_frame_bitmap_allocator_top pfba_checker u_pfba_checker (.*);

/* tb/tb_page_frame_bitmap_allocator_top.sv */
module tb_page_frame_bitmap_allocator_top;

  localparam int unsigned NUM_PAGES  = pfba_pkg::NUM_PAGES_DEF;
  localparam int unsigned PAGE_BYTES = pfba_pkg::PAGE_BYTES_DEF;
  localparam int unsigned MAP_BITS   = pfba_pkg::MAP_BITS;
  localparam int unsigned ADDR_W     = pfba_pkg::ADDR_W;
  localparam int unsigned COUNT_W    = pfba_pkg::COUNT_W;
  localparam int unsigned MODE_W     = pfba_pkg::MODE_W;
  localparam int unsigned STATUS_W   = pfba_pkg::STATUS_W;
  localparam int unsigned MAP_WORDS  = NUM_PAGES / MAP_BITS;
  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned IDLE_PCT   = 21;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  // one result beat
  typedef struct {
    logic [ADDR_W-1:0]  page_address;
    pfba_pkg::status_t  status;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] total_count;
  } frame_reply_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [ADDR_W-1:0]   in_address;
  logic                out_valid;
  logic                out_stall;
  logic [ADDR_W-1:0]   out_page_address;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_free_count;
  logic [COUNT_W-1:0]  out_total_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   cfg_kernel_end_address;

  // shadow allocator state
  logic [MAP_BITS-1:0] used_words  [MAP_WORDS];
  logic [MAP_BITS-1:0] owned_words [MAP_WORDS];
  logic [COUNT_W-1:0]  shadow_free;
  logic [COUNT_W-1:0]  shadow_total;
  logic [ADDR_W-1:0]   free_floor;

  frame_reply_t pending_replies [$];
  int unsigned  error_count    = 0;
  bit           hold_request   = 1'b0;
  bit           steady_traffic = 1'b0;

  page_frame_bitmap_allocator_top #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_mode                (in_mode),
    .in_address             (in_address),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_page_address       (out_page_address),
    .out_status             (out_status),
    .out_free_count         (out_free_count),
    .out_total_count        (out_total_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_kernel_end_address (cfg_kernel_end_address)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * 400000);
    $display("page_frame_bitmap_allocator_top test failed");
    $finish;
  end

  // mark a page used, true if it was free
  function automatic bit claim_page(input int unsigned page);
    if (page >= NUM_PAGES) return 1'b0;
    if (used_words[page >> 5][page % MAP_BITS]) return 1'b0;
    used_words[page >> 5][page % MAP_BITS] = 1'b1;
    if (shadow_free != '0) shadow_free = shadow_free - 1'b1;
    return 1'b1;
  endfunction

  // mark a page free, true if it was used
  function automatic bit release_page(input int unsigned page);
    if (page >= NUM_PAGES) return 1'b0;
    if (!used_words[page >> 5][page % MAP_BITS]) return 1'b0;
    used_words[page >> 5][page % MAP_BITS] = 1'b0;
    if (shadow_free != pfba_pkg::COUNT_MAX) shadow_free = shadow_free + 1'b1;
    return 1'b1;
  endfunction

  // apply one operation to the shadow state and build its result
  function automatic frame_reply_t predict_frame_op(input pfba_pkg::mode_t op,
                                                    input logic [ADDR_W-1:0] addr);
    frame_reply_t r;
    int unsigned  page;
    int unsigned  w;
    int unsigned  b;
    page           = addr / PAGE_BYTES;
    r.page_address = '0;
    r.status       = pfba_pkg::STATUS_IGNORED;
    case (op)
      pfba_pkg::MODE_ALLOC: begin
        r.status = pfba_pkg::STATUS_NO_FREE;
        w = 0;
        while (w < MAP_WORDS && used_words[w] == '1) w++;
        if (w < MAP_WORDS) begin
          b = 0;
          while (used_words[w][b]) b++;
          void'(claim_page(w * MAP_BITS + b));
          owned_words[w][b] = 1'b1;
          r.page_address    = ADDR_W'((w * MAP_BITS + b) * PAGE_BYTES);
          r.status          = pfba_pkg::STATUS_DONE;
        end
      end
      pfba_pkg::MODE_FREE: begin
        if (addr % PAGE_BYTES == 0 && addr >= free_floor && page < NUM_PAGES &&
            owned_words[page >> 5][page % MAP_BITS]) begin
          owned_words[page >> 5][page % MAP_BITS] = 1'b0;
          void'(release_page(page));
          r.status = pfba_pkg::STATUS_DONE;
        end
      end
      pfba_pkg::MODE_ADD: begin
        if (release_page(page)) begin
          if (shadow_total != pfba_pkg::COUNT_MAX) shadow_total = shadow_total + 1'b1;
          r.status = pfba_pkg::STATUS_DONE;
        end
      end
      default: begin
        if (claim_page(page)) r.status = pfba_pkg::STATUS_DONE;
      end
    endcase
    r.free_count  = shadow_free;
    r.total_count = shadow_total;
    return r;
  endfunction

  // mostly low pages, some at the top of memory, a few anywhere
  function automatic int unsigned window_page();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 127);
    if (pick < 9) return $urandom_range(NUM_PAGES - 64, NUM_PAGES - 1);
    return $urandom_range(0, NUM_PAGES - 1);
  endfunction

  function automatic logic [ADDR_W-1:0] window_address();
    int unsigned page;
    page = window_page();
    if ($urandom_range(0, 1)) return ADDR_W'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
    return ADDR_W'(page * PAGE_BYTES);
  endfunction

  // prefer pages handed out by alloc, sometimes misaligned
  function automatic logic [ADDR_W-1:0] free_address();
    int unsigned page;
    int unsigned tries;
    page = window_page();
    for (tries = 0; tries < 8 && !owned_words[page >> 5][page % MAP_BITS]; tries++)
      page = window_page();
    if ($urandom_range(0, 9) == 0)
      return ADDR_W'(page * PAGE_BYTES + $urandom_range(1, PAGE_BYTES - 1));
    return ADDR_W'(page * PAGE_BYTES);
  endfunction

  // offer one beat and record its expected result once taken
  task automatic send_beat(input pfba_pkg::mode_t op, input logic [ADDR_W-1:0] addr);
    while (!steady_traffic && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= op;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(predict_frame_op(op, addr));
  endtask

  task automatic send_random_beat();
    pfba_pkg::mode_t   op;
    logic [ADDR_W-1:0] addr;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      op   = pfba_pkg::MODE_ADD;
      addr = window_address();
    end else if (pick < 55) begin
      op   = pfba_pkg::MODE_ALLOC;
      addr = $urandom();
    end else if (pick < 80) begin
      op   = pfba_pkg::MODE_FREE;
      addr = free_address();
    end else if (pick < 90) begin
      op   = pfba_pkg::MODE_RESERVE;
      addr = window_address();
    end else begin
      op   = pfba_pkg::mode_t'($urandom_range(0, 3));
      addr = $urandom();
    end
    send_beat(op, addr);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_kernel_end(input logic [ADDR_W-1:0] value);
    drain();
    cfg_valid              <= 1'b1;
    cfg_kernel_end_address <= value;
    do @(posedge clk); while (!cfg_ready);
    free_floor = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [ADDR_W-1:0] boundary,
                                  input int unsigned beats, input bit steady);
    write_kernel_end(boundary);
    steady_traffic = steady;
    repeat (beats) send_random_beat();
    steady_traffic = 1'b0;
  endtask

  // everything used and unowned right after reset
  task automatic test_reset_state();
    send_beat(pfba_pkg::MODE_ALLOC,   32'h0000_0000);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_0000);
    send_beat(pfba_pkg::MODE_RESERVE, 32'h0000_5000);
    send_beat(pfba_pkg::MODE_ADD,     32'hFFFF_F000);
    send_beat(pfba_pkg::MODE_RESERVE, 32'hFFFF_FFFF);
    send_beat(pfba_pkg::MODE_FREE,    32'h1000_0000);
  endtask

  // each operation and its no-change paths
  task automatic test_directed_ops();
    send_beat(pfba_pkg::MODE_ADD,     32'h0000_0123);
    send_beat(pfba_pkg::MODE_ADD,     32'h0000_0FFF);
    send_beat(pfba_pkg::MODE_ADD,     32'h0000_1000);
    send_beat(pfba_pkg::MODE_ADD,     32'h0FFF_FFFF);
    send_beat(pfba_pkg::MODE_RESERVE, 32'h0000_1800);
    send_beat(pfba_pkg::MODE_RESERVE, 32'h0000_1000);
    send_beat(pfba_pkg::MODE_ALLOC,   32'h0000_0000);
    send_beat(pfba_pkg::MODE_ALLOC,   32'hFFFF_FFFF);
    send_beat(pfba_pkg::MODE_ALLOC,   32'h0000_0000);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_0004);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_0000);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_0000);
    // owned page released by add, then freed
    send_beat(pfba_pkg::MODE_ADD,     32'h0FFF_F000);
    send_beat(pfba_pkg::MODE_FREE,    32'h0FFF_F000);
  endtask

  // frees against the kernel end boundary
  task automatic test_kernel_end();
    write_kernel_end(32'h0000_2000);
    send_beat(pfba_pkg::MODE_ALLOC,   32'h0000_0000);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_0000);
    send_beat(pfba_pkg::MODE_ADD,     32'h0000_2000);
    send_beat(pfba_pkg::MODE_ALLOC,   32'h0000_0000);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_2000);
    write_kernel_end(32'hFFFF_FFFF);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_0000);
    write_kernel_end(32'h0000_0000);
    send_beat(pfba_pkg::MODE_FREE,    32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    run_random_phase(32'h0000_0000, 250, 1'b0);
    run_random_phase(32'h0002_8000 | $urandom_range(0, PAGE_BYTES - 1), 250, 1'b0);
    run_random_phase(32'hFFFF_FFFF, 150, 1'b0);
    run_random_phase($urandom(), 100, 1'b0);
    run_random_phase(32'h0000_0000, 250, 1'b1);
    run_random_phase(32'h0001_0000, 200, 1'b0);
  endtask

  // receiver holds off while beats keep coming
  task automatic test_back_pressure();
    write_kernel_end(32'h0000_0000);
    hold_request = 1'b1;
    repeat (40) send_random_beat();
  endtask

  // receiver stall
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= !steady_traffic && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // result checker
  initial begin
    frame_reply_t exp;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          log_error($sformatf("unexpected result beat: addr %h status %0d free %0d total %0d",
                              out_page_address, out_status, out_free_count,
                              out_total_count));
        end else begin
          exp = pending_replies.pop_front();
          if (out_page_address !== exp.page_address || out_status !== exp.status ||
              out_free_count !== exp.free_count || out_total_count !== exp.total_count)
            log_error($sformatf({"mismatch: exp addr %h status %0d free %0d total %0d, ",
                                 "got addr %h status %0d free %0d total %0d"},
                                exp.page_address, exp.status, exp.free_count,
                                exp.total_count, out_page_address, out_status,
                                out_free_count, out_total_count));
        end
      end
    end
  end

  // main sequence
  initial begin
    in_valid               <= 1'b0;
    in_mode                <= pfba_pkg::MODE_ALLOC;
    in_address             <= '0;
    cfg_valid              <= 1'b0;
    cfg_kernel_end_address <= '0;
    rst_n                  <= 1'b0;
    for (int i = 0; i < MAP_WORDS; i++) begin
      used_words[i]  = '1;
      owned_words[i] = '0;
    end
    shadow_free  = '0;
    shadow_total = '0;
    free_floor   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_ops();
    test_kernel_end();
    test_random_traffic();
    test_back_pressure();

    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0)
      $display("page_frame_bitmap_allocator_top test passed");
    else
      $display("page_frame_bitmap_allocator_top test failed");
    $finish;
  end

endmodule

/* files.f */
src/pfba_pkg.sv
src/pfba_free_index.sv
src/page_frame_bitmap_allocator_top.sv
src/pfba_checker.sv
tb/tb_page_frame_bitmap_allocator_top.sv
